// ===== rtl/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdt_pkg
// Word formats, microcode and fixed-point helpers for the ray differential
// transfer block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdt_pkg;

    localparam int W = 32;
    localparam int F = 16;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = W'(1) << F;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_SCALE = 2'd1;
    localparam logic [1:0] OP_XFER  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // operand / destination codes
    localparam logic [4:0] SRC_A0   = 5'd0;
    localparam logic [4:0] SRC_B0   = 5'd3;
    localparam logic [4:0] SRC_C0   = 5'd6;
    localparam logic [4:0] SRC_S1   = 5'd9;
    localparam logic [4:0] SRC_S2   = 5'd10;
    localparam logic [4:0] SRC_PX0  = 5'd11;
    localparam logic [4:0] SRC_PY0  = 5'd14;
    localparam logic [4:0] SRC_DX0  = 5'd17;
    localparam logic [4:0] SRC_DY0  = 5'd20;
    localparam logic [4:0] SRC_NORM = 5'd23;
    localparam logic [4:0] SRC_INV  = 5'd24;
    localparam logic [4:0] SRC_RR   = 5'd25;
    localparam logic [4:0] SRC_DT   = 5'd26;
    localparam logic [4:0] SRC_ACC  = 5'd27;
    localparam logic [4:0] SRC_ONE  = 5'd28;
    localparam logic [4:0] SRC_K    = 5'd29;
    localparam logic [4:0] SRC_NONE = 5'd30;

    typedef enum logic [2:0] {
        K_ALU  = 3'd0,
        K_SETF = 3'd1,
        K_INV  = 3'd2,
        K_RCP  = 3'd3,
        K_END  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        M_MUL = 2'd0,
        M_ADD = 2'd1,
        M_SUB = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        t_mode      mode;
        logic [4:0] xs;
        logic [4:0] ys;
        logic [4:0] zs;
        logic       negx;
        logic       cond;
        logic [4:0] dst;
    } t_uop;

    typedef struct packed {
        logic [1:0]   opcode;
        logic [W-1:0] vec_a_x;
        logic [W-1:0] vec_a_y;
        logic [W-1:0] vec_a_z;
        logic [W-1:0] vec_b_x;
        logic [W-1:0] vec_b_y;
        logic [W-1:0] vec_b_z;
        logic [W-1:0] vec_c_x;
        logic [W-1:0] vec_c_y;
        logic [W-1:0] vec_c_z;
        logic [W-1:0] scalar_one;
        logic [W-1:0] scalar_two;
    } t_in_word;

    typedef struct packed {
        logic [W-1:0] pos_dx_x;
        logic [W-1:0] pos_dx_y;
        logic [W-1:0] pos_dx_z;
        logic [W-1:0] pos_dy_x;
        logic [W-1:0] pos_dy_y;
        logic [W-1:0] pos_dy_z;
        logic [W-1:0] dir_dx_x;
        logic [W-1:0] dir_dx_y;
        logic [W-1:0] dir_dx_z;
        logic [W-1:0] dir_dy_x;
        logic [W-1:0] dir_dy_y;
        logic [W-1:0] dir_dy_z;
    } t_out_word;

    typedef struct packed {
        logic         start;
        logic         inv;
        logic [W-1:0] value;
    } t_ru_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] value;
    } t_ru_rsp;

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + W'(1)) : a;
    endfunction

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic t_uop ucode(input logic [1:0] op, input logic [5:0] pc);
        t_uop       u;
        logic [5:0] j;
        logic [5:0] jm;
        logic [4:0] bas;
        logic [4:0] ss;
        logic [4:0] dd;
        logic [4:0] pp;
        logic [4:0] k;
        u = '{kind: K_ALU, mode: M_MUL, xs: SRC_NONE, ys: SRC_ONE, zs: SRC_ACC,
              negx: 1'b0, cond: 1'b0, dst: SRC_NONE};
        j   = '0;
        jm  = '0;
        bas = SRC_A0;
        ss  = SRC_S1;
        dd  = SRC_DX0;
        pp  = SRC_PX0;
        k   = '0;
        unique case (op)
            OP_INIT: begin
                if (pc < 6'd3) begin
                    u.xs   = 5'(SRC_C0 + pc[4:0]);
                    u.ys   = 5'(SRC_C0 + pc[4:0]);
                    u.mode = (pc == 6'd0) ? M_MUL : M_ADD;
                    if (pc == 6'd2) u.dst = SRC_NORM;
                end else if (pc == 6'd3) begin
                    u.kind = K_INV;
                    u.xs   = SRC_NORM;
                    u.dst  = SRC_INV;
                end else if (pc < 6'd34) begin
                    if (pc < 6'd19) begin
                        j = pc - 6'd4;
                    end else begin
                        j   = pc - 6'd19;
                        bas = SRC_B0;
                        ss  = SRC_S2;
                        dd  = SRC_DY0;
                    end
                    if (j < 6'd3) begin
                        u.xs   = 5'(SRC_C0 + j[4:0]);
                        u.ys   = 5'(bas + j[4:0]);
                        u.mode = (j == 6'd0) ? M_MUL : M_ADD;
                        if (j == 6'd2) u.dst = SRC_K;
                    end else begin
                        jm = j - 6'd3;
                        k  = {3'b0, jm[3:2]};
                        case (jm[1:0])
                            2'd0: begin
                                u.xs = SRC_K;
                                u.ys = 5'(SRC_C0 + k);
                            end
                            2'd1: begin
                                u.xs   = SRC_NORM;
                                u.ys   = 5'(bas + k);
                                u.mode = M_SUB;
                            end
                            2'd2: begin
                                u.xs = ss;
                                u.ys = SRC_ACC;
                            end
                            default: begin
                                u.xs  = SRC_ACC;
                                u.ys  = SRC_INV;
                                u.dst = 5'(dd + k);
                            end
                        endcase
                    end
                end else begin
                    u.kind = K_END;
                end
            end
            OP_SCALE: begin
                if (pc < 6'd12) begin
                    u.xs  = 5'(SRC_PX0 + pc[4:0]);
                    u.ys  = SRC_S1;
                    u.dst = 5'(SRC_PX0 + pc[4:0]);
                end else begin
                    u.kind = K_END;
                end
            end
            OP_XFER: begin
                if (pc < 6'd3) begin
                    u.xs   = 5'(SRC_B0 + pc[4:0]);
                    u.ys   = 5'(SRC_A0 + pc[4:0]);
                    u.mode = (pc == 6'd0) ? M_MUL : M_ADD;
                end else if (pc == 6'd3) begin
                    u.kind = K_SETF;
                end else if (pc < 6'd7) begin
                    k      = 5'(pc - 6'd4);
                    u.xs   = 5'(SRC_B0 + k);
                    u.negx = 1'b1;
                    u.cond = 1'b1;
                    u.dst  = 5'(SRC_B0 + k);
                end else if (pc < 6'd10) begin
                    k      = 5'(pc - 6'd7);
                    u.xs   = 5'(SRC_A0 + k);
                    u.ys   = 5'(SRC_B0 + k);
                    u.mode = (k == 5'd0) ? M_MUL : M_ADD;
                end else if (pc == 6'd10) begin
                    u.kind = K_RCP;
                    u.xs   = SRC_ACC;
                    u.dst  = SRC_RR;
                end else if (pc < 6'd31) begin
                    if (pc < 6'd21) begin
                        j = pc - 6'd11;
                    end else begin
                        j  = pc - 6'd21;
                        pp = SRC_PY0;
                        dd = SRC_DY0;
                    end
                    if (j < 6'd3) begin
                        k      = j[4:0];
                        u.xs   = SRC_S1;
                        u.ys   = 5'(dd + k);
                        u.mode = M_ADD;
                        u.zs   = 5'(pp + k);
                        u.dst  = 5'(pp + k);
                    end else if (j < 6'd6) begin
                        k      = 5'(j - 6'd3);
                        u.xs   = 5'(pp + k);
                        u.negx = 1'b1;
                        u.ys   = 5'(SRC_B0 + k);
                        u.mode = (k == 5'd0) ? M_MUL : M_ADD;
                    end else if (j == 6'd6) begin
                        u.xs  = SRC_ACC;
                        u.ys  = SRC_RR;
                        u.dst = SRC_DT;
                    end else begin
                        k      = 5'(j - 6'd7);
                        u.xs   = SRC_DT;
                        u.ys   = 5'(SRC_A0 + k);
                        u.mode = M_ADD;
                        u.zs   = 5'(pp + k);
                        u.dst  = 5'(pp + k);
                    end
                end else begin
                    u.kind = K_END;
                end
            end
            default: u.kind = K_END;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/rdt_recip_unit.sv =====
// ----------------------------------------------------------------------------
// rdt_recip_unit
// Bit-serial reciprocal and inverse norm^1.5: restoring divider passes and a
// digit-by-digit square root, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdt_recip_unit
    import rdt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ru_req i_req,
    output t_ru_rsp o_rsp
);

    localparam int NW = 5 * F + 1;
    localparam int SW = NW + 1;
    localparam int RB = SW / 2;
    localparam int CW = $clog2(NW);

    localparam logic [NW-1:0] NUM_INV = NW'(1) << (5 * F);
    localparam logic [NW-1:0] NUM_RCP = NW'(1) << (2 * F);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_DIV  = 3'b010,
        U_SQRT = 3'b100
    } t_ustate;

    t_ustate         r_state;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_pass;
    logic            r_inv;
    logic            r_neg;
    logic [NW-1:0]   r_num;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_div;
    logic [SW-1:0]   r_sv;
    logic [RB-1:0]   r_root;
    logic [RB+2:0]   r_srem;
    logic            r_done;
    logic [W-1:0]    r_val;

    logic [W:0]      div_trial;
    logic            div_ge;
    logic [NW-1:0]   n_num;
    logic [RB+2:0]   sq_rem;
    logic [RB+2:0]   sq_trial;
    logic            sq_ge;
    logic [W-1:0]    rcp_mag;

    always_comb begin
        div_trial = {r_rem, r_num[NW-1]};
        div_ge    = div_trial >= {1'b0, r_div};
        n_num     = {r_num[NW-2:0], div_ge};
        sq_rem    = {r_srem[RB:0], r_sv[SW-1:SW-2]};
        sq_trial  = {1'b0, r_root, 2'b01};
        sq_ge     = sq_rem >= sq_trial;
        rcp_mag   = (n_num > NW'(WMAX)) ? WMAX : n_num[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_pass  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_inv  <= i_req.inv;
                        r_neg  <= i_req.value[W-1];
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        if (i_req.inv) begin
                            r_num  <= NUM_INV;
                            r_div  <= i_req.value;
                            r_pass <= 2'd2;
                            if (i_req.value[W-1] || i_req.value == '0) begin
                                r_done <= 1'b1;
                                r_val  <= WMAX;
                            end else begin
                                r_state <= U_DIV;
                            end
                        end else begin
                            r_num  <= NUM_RCP;
                            r_div  <= mag(i_req.value);
                            r_pass <= 2'd0;
                            if (i_req.value == '0) begin
                                r_done <= 1'b1;
                                r_val  <= WMAX;
                            end else begin
                                r_state <= U_DIV;
                            end
                        end
                    end
                end
                U_DIV: begin
                    r_num <= n_num;
                    r_rem <= div_ge ? W'(div_trial - {1'b0, r_div}) : div_trial[W-1:0];
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NW - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (r_pass != 2'd0) begin
                            r_pass <= r_pass - 2'd1;
                        end else if (r_inv) begin
                            r_sv    <= {1'b0, n_num};
                            r_root  <= '0;
                            r_srem  <= '0;
                            r_state <= U_SQRT;
                        end else begin
                            r_done  <= 1'b1;
                            r_val   <= r_neg ? (~rcp_mag + W'(1)) : rcp_mag;
                            r_state <= U_IDLE;
                        end
                    end
                end
                U_SQRT: begin
                    r_sv   <= r_sv << 2;
                    r_srem <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
                    r_root <= {r_root[RB-2:0], sq_ge};
                    r_cnt  <= r_cnt + CW'(1);
                    if (r_cnt == CW'(RB - 1)) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_val   <= ({r_root[RB-2:0], sq_ge} > RB'(WMAX)) ? WMAX :
                                   W'({r_root[RB-2:0], sq_ge});
                        r_state <= U_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_rsp = '{done: r_done, value: r_val};

endmodule

// ===== rtl/ray_differential_transfer.sv =====
// ----------------------------------------------------------------------------
// ray_differential_transfer
// Ray differential state with init, scale and surface transfer updates.
// ----------------------------------------------------------------------------
// One word is taken at a time; o_in_stall stays high until its result word is
// loaded into the output register. A microcode sequencer drives one shared
// Q16.16 multiplier with a saturating add/subtract; each step registers the
// product and then accumulates it. Scale runs 12 multiply steps, transfer 29
// multiply steps, one flag step and a bit-serial reciprocal, init 33 multiply
// steps and a norm^-1.5 made of three divider passes and a square root.
// Opcode 3 returns the state unchanged. A stalled previous result word delays
// the load until it is taken.
`timescale 1ns / 1ps

module ray_differential_transfer
    import rdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state          r_state;
    logic [5:0]      r_pc;
    logic [1:0]      r_op;
    logic            r_flag;
    logic [W-1:0]    r_a [3];
    logic [W-1:0]    r_b [3];
    logic [W-1:0]    r_c [3];
    logic [W-1:0]    r_s1;
    logic [W-1:0]    r_s2;
    logic [W-1:0]    r_px [3];
    logic [W-1:0]    r_py [3];
    logic [W-1:0]    r_dx [3];
    logic [W-1:0]    r_dy [3];
    logic [W-1:0]    r_norm;
    logic [W-1:0]    r_inv;
    logic [W-1:0]    r_rr;
    logic [W-1:0]    r_dt;
    logic [W-1:0]    r_k;
    logic [W-1:0]    r_acc;
    logic [2*W-1:0]  r_prod;
    logic            r_pneg;
    t_ru_req         r_req;
    logic            r_out_valid;
    t_out_word       r_out;

    t_ru_rsp         ru_rsp;
    t_uop            uop;
    logic [W-1:0]    xv;
    logic [W-1:0]    yv;
    logic [W-1:0]    zv;
    logic            xneg;
    logic [W-1:0]    xm;
    logic [2*W-F-1:0] sh;
    logic [W:0]      lim;
    logic [W:0]      mm;
    logic [W-1:0]    mres;
    logic [W-1:0]    alu_res;
    logic            we;
    logic [4:0]      wd;
    logic [W-1:0]    wv;

    function automatic logic [W-1:0] src_val(input logic [4:0] s);
        logic [W-1:0] v;
        v = '0;
        case (s)
            5'd0:     v = r_a[0];
            5'd1:     v = r_a[1];
            5'd2:     v = r_a[2];
            5'd3:     v = r_b[0];
            5'd4:     v = r_b[1];
            5'd5:     v = r_b[2];
            5'd6:     v = r_c[0];
            5'd7:     v = r_c[1];
            5'd8:     v = r_c[2];
            SRC_S1:   v = r_s1;
            SRC_S2:   v = r_s2;
            5'd11:    v = r_px[0];
            5'd12:    v = r_px[1];
            5'd13:    v = r_px[2];
            5'd14:    v = r_py[0];
            5'd15:    v = r_py[1];
            5'd16:    v = r_py[2];
            5'd17:    v = r_dx[0];
            5'd18:    v = r_dx[1];
            5'd19:    v = r_dx[2];
            5'd20:    v = r_dy[0];
            5'd21:    v = r_dy[1];
            5'd22:    v = r_dy[2];
            SRC_NORM: v = r_norm;
            SRC_INV:  v = r_inv;
            SRC_RR:   v = r_rr;
            SRC_DT:   v = r_dt;
            SRC_ACC:  v = r_acc;
            SRC_ONE:  v = ONE;
            SRC_K:    v = r_k;
            default:  v = '0;
        endcase
        return v;
    endfunction

    rdt_recip_unit u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (ru_rsp)
    );

    always_comb begin
        uop  = ucode(r_op, r_pc);
        xv   = src_val(uop.xs);
        yv   = src_val(uop.ys);
        zv   = src_val(uop.zs);
        xneg = uop.negx ? ($signed(xv) > 0) : xv[W-1];
        xm   = (uop.negx && xv == WMIN) ? WMAX : mag(xv);
        // saturate the registered product
        sh   = r_prod[2*W-1:F];
        lim  = {1'b0, WMAX} + (W+1)'(r_pneg);
        mm   = (sh > (2*W-F)'(lim)) ? lim : sh[W:0];
        mres = r_pneg ? (~mm[W-1:0] + W'(1)) : mm[W-1:0];
        case (uop.mode)
            M_ADD:   alu_res = sat_add(zv, mres);
            M_SUB:   alu_res = sat_sub(mres, zv);
            default: alu_res = mres;
        endcase
        we = 1'b0;
        wd = uop.dst;
        wv = alu_res;
        if (r_state == S_ACC) begin
            we = (uop.dst != SRC_NONE) && (!uop.cond || r_flag);
        end else if (r_state == S_WAIT) begin
            we = ru_rsp.done;
            wv = ru_rsp.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_px[i] <= '0;
                r_py[i] <= '0;
                r_dx[i] <= '0;
                r_dy[i] <= '0;
            end
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (we) begin
                for (int i = 0; i < 3; i++) begin
                    if (wd == 5'(SRC_A0 + i))  r_a[i]  <= wv;
                    if (wd == 5'(SRC_B0 + i))  r_b[i]  <= wv;
                    if (wd == 5'(SRC_PX0 + i)) r_px[i] <= wv;
                    if (wd == 5'(SRC_PY0 + i)) r_py[i] <= wv;
                    if (wd == 5'(SRC_DX0 + i)) r_dx[i] <= wv;
                    if (wd == 5'(SRC_DY0 + i)) r_dy[i] <= wv;
                end
                if (wd == SRC_NORM) r_norm <= wv;
                if (wd == SRC_INV)  r_inv  <= wv;
                if (wd == SRC_RR)   r_rr   <= wv;
                if (wd == SRC_DT)   r_dt   <= wv;
                if (wd == SRC_K)    r_k    <= wv;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_word.opcode;
                        r_a[0]  <= i_in_word.vec_a_x;
                        r_a[1]  <= i_in_word.vec_a_y;
                        r_a[2]  <= i_in_word.vec_a_z;
                        r_b[0]  <= i_in_word.vec_b_x;
                        r_b[1]  <= i_in_word.vec_b_y;
                        r_b[2]  <= i_in_word.vec_b_z;
                        r_c[0]  <= i_in_word.vec_c_x;
                        r_c[1]  <= i_in_word.vec_c_y;
                        r_c[2]  <= i_in_word.vec_c_z;
                        r_s1    <= i_in_word.scalar_one;
                        r_s2    <= i_in_word.scalar_two;
                        r_pc    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (uop.kind)
                        K_ALU: begin
                            r_prod  <= {{W{1'b0}}, xm} * {{W{1'b0}}, mag(yv)};
                            r_pneg  <= xneg ^ yv[W-1];
                            r_state <= S_ACC;
                        end
                        K_SETF: begin
                            r_flag <= $signed(r_acc) > 0;
                            r_pc   <= r_pc + 6'd1;
                        end
                        K_INV, K_RCP: begin
                            r_req.start <= 1'b1;
                            r_req.inv   <= (uop.kind == K_INV);
                            r_req.value <= xv;
                            r_state     <= S_WAIT;
                        end
                        K_END: r_state <= S_DONE;
                    endcase
                end
                S_ACC: begin
                    r_acc   <= alu_res;
                    r_pc    <= r_pc + 6'd1;
                    r_state <= S_MUL;
                end
                S_WAIT: begin
                    if (ru_rsp.done) begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= '{r_px[0], r_px[1], r_px[2], r_py[0], r_py[1], r_py[2],
                                         r_dx[0], r_dx[1], r_dx[2], r_dy[0], r_dy[1], r_dy[2]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/rdt_checker.sv =====
// ----------------------------------------------------------------------------
// rdt_checker
// Port-level checks for the ray differential transfer block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdt_checker
    import rdt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result word appeared right after accept");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a word in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

bind ray_differential_transfer rdt_checker u_rdt_checker (.*);
